>>> src/rbj_pkg.sv
// shared types and constants for the reconnect back-off generator
`timescale 1ns / 1ps

package rbj_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_INTERVAL  = 2'd0;
    localparam logic [1:0] CFG_JITTER_ENABLE = 2'd1;
    localparam logic [1:0] CFG_SEED_VALUE    = 2'd2;

    // fold constant for the generator seed
    localparam logic [31:0] GOLDEN_WORD = 32'h9E37_79B9;

    // restoring remainder steps, one per generator bit
    localparam int DIV_STEPS = 32;
    localparam int CNT_BITS  = $clog2(DIV_STEPS);

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_PREP,
        ST_DIV,
        ST_SUM,
        ST_DONE
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load_in;
        logic load_sum_base;
        logic prep;
        logic div_step;
        logic load_sum;
        logic load_out;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic bypass;
    } t_status;

endpackage

>>> src/reconnect_backoff_jitter.sv
// top level of the reconnect back-off interval generator with jitter
//
// Input channel: i_valid / o_stall carry one word, i_current_interval. A word
// is taken when i_valid is high and o_stall is low; o_stall is low only while
// the controller is idle, so one word is in work at a time.
// Output channel: o_valid / i_stall carry next_interval from an output
// register. The next input word is taken while a finished word still waits.
// Config: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data; index 0
// is max_interval, 1 jitter_enable, 2 seed_value. o_cfg_ready is always high.
// A word goes from the base step straight to the output register when jitter
// is off or the base is zero; with jitter it first passes prep, the restoring
// remainder unit, which takes one bit of the 32-bit generator word a cycle,
// and the sum step. The next word is taken once the controller is idle again.
// A stalled receiver holds the output word; a finished word then waits in the
// controller until the output register frees up.
// Synchronous reset (i_rst_n low) clears the generator word to unseeded, sets
// max_interval and seed_value to 0, jitter_enable to 1, and drops o_valid.
`timescale 1ns / 1ps

module reconnect_backoff_jitter import rbj_pkg::*; #(
    parameter int INTERVAL_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [INTERVAL_BITS-1:0] i_current_interval,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [INTERVAL_BITS:0]   o_next_interval,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [63:0]              i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    // sequencing
    rbj_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // arithmetic and state
    rbj_dp #(
        .INTERVAL_BITS (INTERVAL_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_current_interval (i_current_interval),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_next_interval    (o_next_interval)
    );

endmodule

>>> src/rbj_dp.sv
// datapath: config registers, base interval, generator, remainder unit, output word
`timescale 1ns / 1ps

module rbj_dp import rbj_pkg::*; #(
    parameter int INTERVAL_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  logic [1:0]               i_cfg_index,
    input  logic [63:0]              i_cfg_data,
    input  logic [INTERVAL_BITS-1:0] i_current_interval,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    output logic [INTERVAL_BITS:0]   o_next_interval
);

    localparam int IW = INTERVAL_BITS;

    // configuration and generator state
    logic [IW-1:0] r_max_interval;
    logic          r_jitter_enable;
    logic [63:0]   r_seed_value;
    logic [31:0]   r_prng, n_prng;

    // working registers
    logic [IW-1:0] r_base, n_base;
    logic [IW-1:0] r_band, n_band;
    logic [IW-1:0] r_span, n_span;
    logic [IW-1:0] r_rem, n_rem;
    logic [31:0]   r_dividend;
    logic [IW:0]   r_sum, n_sum;
    logic [IW:0]   r_out, n_out;

    logic [31:0]   seed_fold;
    logic [31:0]   prng_start;
    logic [IW:0]   rem_sh;
    logic [IW:0]   rem_sub;

    // config writes and generator word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_interval  <= '0;
            r_jitter_enable <= 1'b1;
            r_seed_value    <= '0;
            r_prng          <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MAX_INTERVAL:  r_max_interval  <= i_cfg_data[IW-1:0];
                    CFG_JITTER_ENABLE: r_jitter_enable <= i_cfg_data[0];
                    CFG_SEED_VALUE:    r_seed_value    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.prep) begin
                r_prng <= n_prng;
            end
        end
    end

    // base interval: doubled, capped, or untouched when the cap is zero
    always_comb begin
        if (r_max_interval == '0) begin
            n_base = i_current_interval;
        end else if (i_current_interval >= r_max_interval ||
                     i_current_interval > (r_max_interval >> 1)) begin
            n_base = r_max_interval;
        end else begin
            n_base = {i_current_interval[IW-2:0], 1'b0};
        end
    end

    // seed on first use, then one xorshift32 advance
    always_comb begin
        seed_fold  = r_seed_value[31:0] ^ r_seed_value[63:32] ^ GOLDEN_WORD;
        prng_start = r_prng;
        if (r_prng == '0) begin
            prng_start = (seed_fold == '0) ? GOLDEN_WORD : seed_fold;
        end
        n_prng = prng_start ^ (prng_start << 13);
        n_prng = n_prng ^ (n_prng >> 17);
        n_prng = n_prng ^ (n_prng << 5);
    end

    // band is a quarter of the base, at least one
    always_comb begin
        n_band = r_base >> 2;
        if (n_band == '0) begin
            n_band = {{(IW-1){1'b0}}, 1'b1};
        end
        n_span = {n_band[IW-2:0], 1'b1};
    end

    // one restoring remainder step
    always_comb begin
        rem_sh  = {r_rem, r_dividend[31]};
        rem_sub = rem_sh - {1'b0, r_span};
        n_rem   = (rem_sh >= {1'b0, r_span}) ? rem_sub[IW-1:0] : rem_sh[IW-1:0];
    end

    // jittered sum and final clamp to the cap when the cap is nonzero
    always_comb begin
        n_sum = {1'b0, r_base} + {1'b0, r_rem} - {1'b0, r_band};
        n_out = r_sum;
        if (r_max_interval != '0 && r_sum > {1'b0, r_max_interval}) begin
            n_out = {1'b0, r_max_interval};
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_base <= n_base;
        end
        if (i_cmd.prep) begin
            r_band     <= n_band;
            r_span     <= n_span;
            r_dividend <= n_prng;
            r_rem      <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem      <= n_rem;
            r_dividend <= {r_dividend[30:0], 1'b0};
        end
        if (i_cmd.load_sum_base) begin
            r_sum <= {1'b0, r_base};
        end
        if (i_cmd.load_sum) begin
            r_sum <= n_sum;
        end
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    assign o_status.bypass = (r_base == '0) || !r_jitter_enable;
    assign o_next_interval = r_out;

endmodule

>>> src/rbj_ctrl.sv
// controller: sequencing of one interval word and the output handshake
`timescale 1ns / 1ps

module rbj_ctrl import rbj_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state              r_state, n_state;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    logic                out_free;

    // state, step counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign out_free = !r_out_valid || !i_stall;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_stall;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_BASE;
                end
            end
            ST_BASE: begin
                if (i_status.bypass) begin
                    o_cmd.load_sum_base = 1'b1;
                    n_state             = ST_DONE;
                end else begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt      = '0;
                n_state    = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_BITS'(DIV_STEPS - 1)) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                o_cmd.load_sum = 1'b1;
                n_state        = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;

    // an accepted word always starts at the base step
    a_accept_to_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == ST_BASE))
        else $error("accepted word did not move to base step");

    // output register is never overwritten while a stalled word waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || !i_stall))
        else $error("output word overwritten under stall");

    // last remainder step is followed by the sum
    a_div_to_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt == CNT_BITS'(DIV_STEPS - 1)) |=> (r_state == ST_SUM))
        else $error("remainder unit did not finish after all steps");

    // remainder steps always begin from a cleared count
    a_prep_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PREP) |=> (r_state == ST_DIV && r_cnt == '0))
        else $error("remainder count not cleared at start");

endmodule

>>> tb/sv/tb_top.sv
// self-checking testbench for the reconnect back-off interval generator with jitter
`timescale 1ns / 1ps

module tb_top;
    import rbj_pkg::*;

    localparam int IVL_W           = 24;
    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 3;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = 45;
    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 172;
    localparam int HOLD_CYCLES     = 300;
    localparam int N_ROWS          = 32;

    localparam logic [1:0]       CFG_UNUSED = 2'd3;
    localparam logic [31:0]      JITTER_PCT = 32'd25;
    localparam logic [31:0]      PCT_SCALE  = 32'd100;
    localparam int               XS_A       = 13;
    localparam int               XS_B       = 17;
    localparam int               XS_C       = 5;
    localparam logic [IVL_W-1:0] IVL_MAX    = '1;

    typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

    typedef struct packed {
        row_kind_e        kind;
        logic [1:0]       idx;
        logic [63:0]      data;
        logic [IVL_W-1:0] cur;
        logic             typed;
        logic [IVL_W:0]   want;
    } stim_row_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [IVL_W-1:0] i_current_interval;
    logic             o_valid;
    logic             i_stall;
    logic [IVL_W:0]   o_next_interval;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [1:0]       i_cfg_index;
    logic [63:0]      i_cfg_data;

    // shadow of the block's registers and generator word
    logic [IVL_W-1:0] cap_reg;
    logic             jitter_on;
    logic [63:0]      seed_reg;
    logic [31:0]      rng_word;

    logic [IVL_W:0] pending_next[$];
    int             errors        = 0;
    int             cycle_count   = 0;
    int             hold_request  = 0;
    int unsigned    idle_pct      = 0;
    int unsigned    stall_pct     = 0;

    // directed words: extremes, cap edges, seed that folds to zero, no-op register
    stim_row_t directed_rows [N_ROWS] = '{
        '{ROW_CFG,  CFG_SEED_VALUE,    64'h0000_0000_9E37_79B9, 24'd0,   1'b0, 25'd0},
        '{ROW_WORD, CFG_MAX_INTERVAL,  64'd0, 24'd0,        1'b1, 25'd0},
        '{ROW_WORD, CFG_MAX_INTERVAL,  64'd0, 24'd1,        1'b0, 25'd0},
        '{ROW_WORD, CFG_MAX_INTERVAL,  64'd0, 24'hFF_FFFF,  1'b0, 25'd0},
        '{ROW_WORD, CFG_MAX_INTERVAL,  64'd0, 24'd3,        1'b0, 25'd0},
        '{ROW_CFG,  CFG_MAX_INTERVAL,  64'hFFFF_FFFF_FF00_03E8, 24'd0, 1'b0, 25'd0},
        '{ROW_WORD, CFG_MAX_INTERVAL,  64'd0, 24'd1,        1'b0, 25'd0},
        '{ROW_WORD, CFG_MAX_INTERVAL,  64'd0, 24'd600,      1'b0, 25'd0},
        '{ROW_WORD, CFG_MAX_INTERVAL,  64'd0, 24'd1000,     1'b0, 25'd0},
        '{ROW_CFG,  CFG_JITTER_ENABLE, 64'hFFFF_FFFF_FFFF_FFFE, 24'd0, 1'b0, 25'd0},
        '{ROW_WORD, CFG_MAX_INTERVAL,  64'd0, 24'd0,        1'b1, 25'd0},
        '{ROW_WORD, CFG_MAX_INTERVAL,  64'd0, 24'd300,      1'b1, 25'd600},
        '{ROW_WORD, CFG_MAX_INTERVAL,  64'd0, 24'd500,      1'b1, 25'd1000},
        '{ROW_WORD, CFG_MAX_INTERVAL,  64'd0, 24'd501,      1'b1, 25'd1000},
        '{ROW_WORD, CFG_MAX_INTERVAL,  64'd0, 24'd1000,     1'b1, 25'd1000},
        '{ROW_WORD, CFG_MAX_INTERVAL,  64'd0, 24'hFF_FFFF,  1'b1, 25'd1000},
        '{ROW_CFG,  CFG_UNUSED,        64'hFFFF_FFFF_FFFF_FFFF, 24'd0, 1'b0, 25'd0},
        '{ROW_WORD, CFG_MAX_INTERVAL,  64'd0, 24'd300,      1'b1, 25'd600},
        '{ROW_CFG,  CFG_MAX_INTERVAL,  64'd0, 24'd0,        1'b0, 25'd0},
        '{ROW_WORD, CFG_MAX_INTERVAL,  64'd0, 24'hFF_FFFF,  1'b1, 25'h0FF_FFFF},
        '{ROW_WORD, CFG_MAX_INTERVAL,  64'd0, 24'd1,        1'b1, 25'd1},
        '{ROW_CFG,  CFG_MAX_INTERVAL,  64'h0000_0000_00FF_FFFF, 24'd0, 1'b0, 25'd0},
        '{ROW_WORD, CFG_MAX_INTERVAL,  64'd0, 24'h7F_FFFF,  1'b1, 25'h0FF_FFFE},
        '{ROW_WORD, CFG_MAX_INTERVAL,  64'd0, 24'h80_0000,  1'b1, 25'h0FF_FFFF},
        '{ROW_WORD, CFG_MAX_INTERVAL,  64'd0, 24'hFF_FFFF,  1'b1, 25'h0FF_FFFF},
        '{ROW_CFG,  CFG_JITTER_ENABLE, 64'd1, 24'd0,        1'b0, 25'd0},
        '{ROW_WORD, CFG_MAX_INTERVAL,  64'd0, 24'hFF_FFFF,  1'b0, 25'd0},
        '{ROW_WORD, CFG_MAX_INTERVAL,  64'd0, 24'd1,        1'b0, 25'd0},
        '{ROW_CFG,  CFG_MAX_INTERVAL,  64'd1, 24'd0,        1'b0, 25'd0},
        '{ROW_WORD, CFG_MAX_INTERVAL,  64'd0, 24'd0,        1'b1, 25'd0},
        '{ROW_WORD, CFG_MAX_INTERVAL,  64'd0, 24'd1,        1'b0, 25'd0},
        '{ROW_WORD, CFG_MAX_INTERVAL,  64'd0, 24'hFF_FFFF,  1'b0, 25'd0}
    };

    reconnect_backoff_jitter #(
        .INTERVAL_BITS(IVL_W)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_current_interval (i_current_interval),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_next_interval    (o_next_interval),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // xorshift32 step, seeding from the folded seed on first use
    function automatic logic [31:0] advance_jitter_rng();
        logic [31:0] x;
        x = rng_word;
        if (x == '0) begin
            x = seed_reg[31:0] ^ seed_reg[63:32] ^ GOLDEN_WORD;
            if (x == '0) x = GOLDEN_WORD;
        end
        x = x ^ (x << XS_A);
        x = x ^ (x >> XS_B);
        x = x ^ (x << XS_C);
        rng_word = x;
        return x;
    endfunction

    // doubled and capped base, plus jitter within a quarter of it, clamped
    function automatic logic [IVL_W:0] predict_next_interval(input logic [IVL_W-1:0] cur);
        logic [IVL_W-1:0] base;
        logic [31:0]      band;
        logic [31:0]      span;
        logic [31:0]      offset;
        logic [31:0]      sum;
        if (cap_reg == '0)
            base = cur;
        else if (cur >= cap_reg || cur > (cap_reg >> 1))
            base = cap_reg;
        else
            base = cur << 1;
        if (base == '0 || !jitter_on) return {1'b0, base};
        band = ({8'd0, base} * JITTER_PCT) / PCT_SCALE;
        if (band == '0) band = 32'd1;
        span   = (band << 1) + 32'd1;
        offset = advance_jitter_rng() % span;
        sum    = {8'd0, base} + offset;
        if (sum < band)
            sum = '0;
        else
            sum = sum - band;
        if (cap_reg != '0 && sum > {8'd0, cap_reg}) sum = {8'd0, cap_reg};
        return sum[IVL_W:0];
    endfunction

    // register write, shadow updated on the handshake
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MAX_INTERVAL:  cap_reg   = data[IVL_W-1:0];
            CFG_JITTER_ENABLE: jitter_on = data[0];
            CFG_SEED_VALUE:    seed_reg  = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // drop valid, let every expected word arrive, then let the block settle
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_next.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // offer one word, with an optional gap before it
    task automatic send_word(input logic [IVL_W-1:0] cur, input logic typed,
                             input logic [IVL_W:0] want);
        logic [IVL_W:0] predicted;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            repeat (($urandom_range(7) == 0) ? $urandom_range(4, 45) : $urandom_range(1, 3))
                @(posedge i_clk);
        end
        i_valid            <= 1'b1;
        i_current_interval <= cur;
        do @(posedge i_clk); while (o_stall);
        predicted = predict_next_interval(cur);
        pending_next.push_back(typed ? want : predicted);
    endtask

    // receiver: random stall, or a long hold-off on request
    initial begin
        int n;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                n = hold_request;
                hold_request = 0;
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                i_stall <= (stall_pct != 0 && $urandom_range(99) < stall_pct);
            end
        end
    end

    // compare each accepted result word with the oldest expectation
    always @(posedge i_clk) begin : check_results
        logic [IVL_W:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_next.size() == 0) begin
                errors++;
                $display("%0t: next_interval %0d with no word expected", $time,
                         o_next_interval);
            end else begin
                want = pending_next.pop_front();
                if (o_next_interval !== want) begin
                    errors++;
                    $display("%0t: next_interval mismatch: expected %0d, actual %0d",
                             $time, want, o_next_interval);
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** reconnect_backoff_jitter: FAILED **");
        $finish;
    end

    // stimulus
    initial begin
        logic [IVL_W-1:0] cap_pick;
        logic [IVL_W-1:0] cur;
        logic [63:0]      cfg_word;
        int               mode;
        i_rst_n            <= 1'b0;
        i_valid            <= 1'b0;
        i_current_interval <= '0;
        i_cfg_valid        <= 1'b0;
        i_cfg_index        <= CFG_MAX_INTERVAL;
        i_cfg_data         <= '0;
        cap_reg   = '0;
        jitter_on = 1'b1;
        seed_reg  = '0;
        rng_word  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed_rows[n]) begin
            if (directed_rows[n].kind == ROW_CFG) begin
                wait_idle();
                write_reg(directed_rows[n].idx, directed_rows[n].data);
            end else begin
                send_word(directed_rows[n].cur, directed_rows[n].typed, directed_rows[n].want);
            end
        end

        // random phases, each with its own settings and idling mix
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            case ($urandom_range(4))
                0:       cap_pick = '0;
                1:       cap_pick = IVL_W'(1);
                2:       cap_pick = IVL_MAX;
                3:       cap_pick = IVL_W'($urandom_range(2, 4000));
                default: cap_pick = IVL_W'($urandom());
            endcase
            cfg_word = {$urandom(), $urandom()};
            write_reg(CFG_MAX_INTERVAL, {cfg_word[63:IVL_W], cap_pick});
            cfg_word = {$urandom(), $urandom()};
            write_reg(CFG_JITTER_ENABLE, {cfg_word[63:1], ($urandom_range(3) != 0)});
            write_reg(CFG_SEED_VALUE, {$urandom(), $urandom()});
            if ($urandom_range(1) == 0) write_reg(CFG_UNUSED, {$urandom(), $urandom()});

            mode      = ph % 4;
            idle_pct  = (mode == 1) ? 66 : (mode == 3) ? 33 : 0;
            stall_pct = (mode == 2) ? 66 : (mode == 3) ? 33 : 0;

            for (int w = 0; w < WORDS_PER_PHASE; w++) begin
                // long receiver hold-off so the block backs up into its input
                if (mode == 0 && w == 40) hold_request = HOLD_CYCLES;
                case ($urandom_range(9))
                    0:       cur = '0;
                    1:       cur = IVL_MAX;
                    2:       cur = IVL_W'($urandom_range(1, 15));
                    3:       cur = IVL_W'(cap_reg + $urandom_range(0, 4) - 2);
                    4:       cur = IVL_W'((cap_reg >> 1) + $urandom_range(0, 4) - 2);
                    default: cur = IVL_W'($urandom());
                endcase
                send_word(cur, 1'b0, '0);
            end
        end

        wait_idle();
        if (errors == 0 && pending_next.size() == 0)
            $display("** reconnect_backoff_jitter: PASSED **");
        else
            $display("** reconnect_backoff_jitter: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
src/rbj_pkg.sv
src/rbj_dp.sv
src/rbj_ctrl.sv
src/reconnect_backoff_jitter.sv
tb/sv/tb_top.sv
